>>> rtl/file_table_block_allocator_unit_assert.svh
// Assertion macros used by the allocator datapath
`ifndef FILE_TABLE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FILE_TABLE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define FTBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define FTBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/ftba_pkg.sv
// -----------------------------------------------------------------------------
// ftba_pkg
// Shared types and codes for the file table block allocator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ftba_pkg;
  // table geometry, fixed by the result field widths
  localparam int NUM_ENTRIES     = 16;
  localparam int NUM_BLOCKS      = 128;
  localparam int BLOCKS_PER_FILE = 8;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_BADARG   = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input transaction
    logic search;   // register table / bitmap search results
    logic commit;   // perform state update and form result
  } ftba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;     // allocate or free pass still walking slots
  } ftba_stat_t;
endpackage
`default_nettype wire

>>> rtl/file_table_block_allocator_unit.sv
// -----------------------------------------------------------------------------
// file_table_block_allocator_unit
// File table with bitmap block allocator: create, delete, look up.
// -----------------------------------------------------------------------------
// One command at a time. Each command goes through load, search, commit and
// a wait state before the result is offered. A successful create or delete
// also walks the file's slots during the wait, one block per cycle, and the
// result is offered once that walk finishes. The result is held until taken
// and the next command is accepted in the cycle after that.
`timescale 1ns / 1ps
`default_nettype none
module file_table_block_allocator_unit
  import ftba_pkg::*;
#(
  parameter int NAME_BITS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [1:0] command, [65:2] file_name, [69:66] block_count, [72:70] block_index
  input  wire  [79:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [2:0] status, [9:3] block_number, [13:10] entry_index
  output logic [15:0] out_tdata
);
  ftba_cmd_t  cmd;
  ftba_stat_t stat;
  logic [2:0] st;
  logic [6:0] blk;
  logic [3:0] ent;

  wire in_fire  = in_tvalid && in_tready;
  wire out_fire = out_tvalid && out_tready;

  ftba_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .cmd,
    .in_ready(in_tready), .out_valid(out_tvalid)
  );

  ftba_dp #(
    .NAME_BITS(NAME_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_command(in_tdata[1:0]), .in_file_name(in_tdata[65:2]),
    .in_blk_count(in_tdata[69:66]), .in_block_index(in_tdata[72:70]),
    .res_status(st), .res_block(blk), .res_entry(ent)
  );

  assign out_tdata = {2'b00, ent, blk, st};
endmodule
`default_nettype wire

>>> rtl/ftba_ctrl.sv
// -----------------------------------------------------------------------------
// ftba_ctrl
// Command sequencer: load, search, commit, wait for any slot pass, then hold the result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ftba_ctrl
  import ftba_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_fire,
  input  wire        out_fire,
  input  ftba_stat_t stat,
  output ftba_cmd_t  cmd,
  output logic       in_ready,
  output logic       out_valid
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_COMMIT = 5'b00100,
    S_WAIT   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_SEARCH;
      S_SEARCH: state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_WAIT;
      S_WAIT:   if (!stat.busy) state_nxt = S_OUT;
      S_OUT:    if (out_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.load    = in_fire;
  assign cmd.search  = (state_r == S_SEARCH);
  assign cmd.commit  = (state_r == S_COMMIT);
endmodule
`default_nettype wire

>>> rtl/ftba_dp.sv
// -----------------------------------------------------------------------------
// ftba_dp
// Table, free bitmap, block slots and the search / update datapath.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ftba_dp
  import ftba_pkg::*;
#(
  parameter int NAME_BITS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  ftba_cmd_t   cmd,
  output ftba_stat_t  stat,
  input  wire  [1:0]  in_command,
  input  wire  [63:0] in_file_name,
  input  wire  [3:0]  in_blk_count,
  input  wire  [2:0]  in_block_index,
  output logic [2:0]  res_status,
  output logic [6:0]  res_block,
  output logic [3:0]  res_entry
);
  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int SW = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;
  localparam int CW = $clog2(BLOCKS_PER_FILE + 1);

  logic [1:0]           cmd_r;
  logic [NAME_BITS-1:0] name_r;
  logic [3:0]           size_r;
  logic [2:0]           idx_r;

  logic [NUM_ENTRIES-1:0]                  used_r;
  logic [NAME_BITS-1:0]                    ename_r [NUM_ENTRIES];
  logic [3:0]                              esize_r [NUM_ENTRIES];
  logic [BLOCKS_PER_FILE-1:0][BW-1:0]      eblk_r  [NUM_ENTRIES];
  logic [NUM_BLOCKS-1:0]                   map_r;
  logic [BW-1:0]                           free_cnt_r;

  // search results
  logic          hit_r, free_ok_r;
  logic [EW-1:0] hit_e_r, free_e_r;
  logic          space_r;

  logic          hit_c, free_ok_c;
  logic [EW-1:0] hit_e_c, free_e_c;
  logic [NUM_ENTRIES-1:0] match_c;

  // delete free pass
  logic          del_r;
  logic [EW-1:0] del_e_r;
  logic [CW-1:0] del_k_r;

  // create allocate pass
  logic          al_r;
  logic [EW-1:0] al_e_r;
  logic [CW-1:0] al_k_r;

  // lowest free block
  logic [BW-1:0] low_c;

  // commit decision
  logic [2:0] st_c;
  logic [6:0] blk_c;
  logic [3:0] ent_c;
  logic       mk_c, rm_c;

  always_comb begin
    hit_c = 1'b0; hit_e_c = '0; free_ok_c = 1'b0; free_e_c = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      match_c[e] = used_r[e] && (ename_r[e] == name_r);
      if (match_c[e]) begin
        hit_c = 1'b1; hit_e_c = EW'(e);
      end
      if (!used_r[e]) begin
        free_ok_c = 1'b1; free_e_c = EW'(e);
      end
    end
  end

  always_comb begin
    low_c = '0;
    for (int b = NUM_BLOCKS - 1; b >= 1; b--)
      if (!map_r[b]) low_c = BW'(b);
  end

  wire [EW-1:0] e_sel  = hit_e_r;
  wire [3:0]    e_size = esize_r[e_sel];
  wire [BW-1:0] e_blk  = eblk_r[e_sel][idx_r[SW-1:0]];
  wire          size_bad = (size_r > 4'(BLOCKS_PER_FILE));
  wire          al_step  = al_r && (4'(al_k_r) < esize_r[al_e_r]);

  assign stat.busy = del_r || al_r;

  always_comb begin
    st_c = ST_BADARG; blk_c = '0; ent_c = '0; mk_c = 1'b0; rm_c = 1'b0;
    case (cmd_r)
      CMD_CREATE: begin
        if (size_bad) st_c = ST_BADARG;
        else if (!free_ok_r) st_c = ST_FULL;
        else if (hit_r) st_c = ST_DUP;
        else if (!space_r) st_c = ST_NOSPACE;
        else begin
          st_c  = ST_OK;
          ent_c = 4'(free_e_r);
          mk_c  = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (!hit_r) st_c = ST_NOTFOUND;
        else begin
          st_c  = ST_OK;
          ent_c = 4'(hit_e_r);
          rm_c  = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (!hit_r || 4'(idx_r) >= e_size || 32'(idx_r) >= BLOCKS_PER_FILE
            || !map_r[e_blk]) st_c = ST_NOTFOUND;
        else begin
          st_c  = ST_OK;
          ent_c = 4'(hit_e_r);
          blk_c = 7'(e_blk);
        end
      end
      default: st_c = ST_BADARG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      name_r <= in_file_name[NAME_BITS-1:0];
      size_r <= in_blk_count;
      idx_r  <= in_block_index;
    end
    if (cmd.search) begin
      hit_r <= hit_c; hit_e_r <= hit_e_c;
      free_ok_r <= free_ok_c; free_e_r <= free_e_c;
      space_r <= (free_cnt_r >= BW'(size_r)) && !size_bad;
    end
    if (cmd.commit) begin
      res_status <= st_c;
      res_block  <= blk_c;
      res_entry  <= ent_c;
      if (mk_c) begin
        ename_r[free_e_r] <= name_r;
        esize_r[free_e_r] <= size_r;
      end
    end
    // slots at or above the size are never read
    if (al_step) eblk_r[al_e_r][al_k_r[SW-1:0]] <= low_c;
  end

  // control state: used bits, bitmap, free count, slot walkers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      map_r      <= NUM_BLOCKS'(1);
      free_cnt_r <= BW'(NUM_BLOCKS - 1);
      del_r      <= 1'b0;
      del_e_r    <= '0;
      del_k_r    <= '0;
      al_r       <= 1'b0;
      al_e_r     <= '0;
      al_k_r     <= '0;
    end else begin
      if (cmd.commit && mk_c) begin
        used_r[free_e_r] <= 1'b1;
        free_cnt_r <= free_cnt_r - BW'(size_r);
        al_r   <= 1'b1;
        al_e_r <= free_e_r;
        al_k_r <= '0;
      end
      if (cmd.commit && rm_c) begin
        used_r[hit_e_r] <= 1'b0;
        del_r   <= 1'b1;
        del_e_r <= hit_e_r;
        del_k_r <= '0;
      end
      // one block taken per cycle, always the lowest free one
      if (al_r) begin
        if (al_step) begin
          map_r[low_c] <= 1'b1;
          al_k_r <= al_k_r + CW'(1);
        end else begin
          al_r <= 1'b0;
        end
      end
      // one slot freed per cycle; block 0 never freed
      if (del_r) begin
        if (del_k_r < CW'(BLOCKS_PER_FILE) && 4'(del_k_r) < esize_r[del_e_r]) begin
          if (eblk_r[del_e_r][del_k_r[SW-1:0]] != '0) begin
            map_r[eblk_r[del_e_r][del_k_r[SW-1:0]]] <= 1'b0;
            free_cnt_r <= free_cnt_r + BW'(1);
          end
          del_k_r <= del_k_r + 1'b1;
        end else begin
          del_r <= 1'b0;
        end
      end
    end
  end

`include "file_table_block_allocator_unit_assert.svh"
  `FTBA_ASSERT_IMP(a_blk0_used, clk, rst_n, 1'b1, map_r[0], "block 0 freed")
  `FTBA_ASSERT_IMP(a_no_overlap, clk, rst_n, cmd.commit, !stat.busy, "commit during slot pass")
  `FTBA_ASSERT_NEXT(a_load_clears_del, clk, rst_n, cmd.load, !del_r, "load while freeing")
endmodule
`default_nettype wire

>>> bench/file_table_block_allocator_unit_checker.sv
// -----------------------------------------------------------------------------
// file_table_block_allocator_unit_checker
// Watches both streams, keeps a shadow file table and free map, and compares
// every result transaction with the predicted status, block and entry.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module file_table_block_allocator_unit_checker
  import ftba_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [79:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [15:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int ENTRIES = 16;
  localparam int BLOCKS  = 128;
  localparam int PER     = 8;

  typedef struct packed {
    logic [3:0] entry;
    logic [6:0] blk;
    logic [2:0] status;
  } alloc_result_t;

  logic        tbl_used [ENTRIES];
  logic [63:0] tbl_name [ENTRIES];
  logic [3:0]  tbl_size [ENTRIES];
  logic [6:0]  tbl_blk  [ENTRIES][PER];
  logic        blk_taken[BLOCKS];

  alloc_result_t expected_results[$];

  function automatic int match_entry(logic [63:0] nm);
    for (int e = 0; e < ENTRIES; e++)
      if (tbl_used[e] && tbl_name[e] == nm) return e;
    return -1;
  endfunction

  function automatic alloc_result_t apply_command(logic [79:0] d);
    logic [1:0]    cmd;
    logic [63:0]   nm;
    logic [3:0]    sz;
    logic [2:0]    idx;
    alloc_result_t r;
    int            e, slot, cnt;
    logic [6:0]    got[PER];
    cmd = d[1:0]; nm = d[65:2]; sz = d[69:66]; idx = d[72:70];
    r = '0;
    r.status = ST_BADARG;
    if (cmd == CMD_CREATE) begin
      slot = -1;
      for (e = ENTRIES - 1; e >= 0; e--) if (!tbl_used[e]) slot = e;
      cnt = 0;
      for (int b = 1; b < BLOCKS; b++)
        if (!blk_taken[b] && cnt < sz && cnt < PER) begin
          got[cnt] = b[6:0];
          cnt++;
        end
      if (sz > PER) r.status = ST_BADARG;
      else if (slot < 0) r.status = ST_FULL;
      else if (match_entry(nm) >= 0) r.status = ST_DUP;
      else if (cnt != sz) r.status = ST_NOSPACE;
      else begin
        tbl_used[slot] = 1; tbl_name[slot] = nm; tbl_size[slot] = sz;
        for (int k = 0; k < PER; k++) tbl_blk[slot][k] = (k < sz) ? got[k] : '0;
        for (int k = 0; k < sz; k++) blk_taken[got[k]] = 1;
        r.status = ST_OK; r.entry = slot[3:0];
      end
    end else if (cmd == CMD_DELETE) begin
      e = match_entry(nm);
      if (e < 0) r.status = ST_NOTFOUND;
      else begin
        for (int k = 0; k < tbl_size[e]; k++)
          if (tbl_blk[e][k] != 0) blk_taken[tbl_blk[e][k]] = 0;
        tbl_used[e] = 0; tbl_size[e] = 0; tbl_name[e] = '0;
        r.status = ST_OK; r.entry = e[3:0];
      end
    end else if (cmd == CMD_LOOKUP) begin
      e = match_entry(nm);
      r.status = ST_NOTFOUND;
      if (e >= 0 && idx < tbl_size[e] && blk_taken[tbl_blk[e][idx]]) begin
        r.status = ST_OK; r.entry = e[3:0]; r.blk = tbl_blk[e][idx];
      end
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  initial begin
    fail_count = 0;
    for (int e = 0; e < ENTRIES; e++) begin
      tbl_used[e] = 0; tbl_size[e] = 0; tbl_name[e] = '0;
    end
    for (int b = 0; b < BLOCKS; b++) blk_taken[b] = (b == 0);
  end

  always @(posedge clk) begin
    alloc_result_t got_r, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_results.push_back(apply_command(in_tdata));
      if (out_tvalid && out_tready) begin
        got_r = out_tdata[13:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got_r.status !== want.status)
            $display("%0t: status exp %0d got %0d", $realtime, want.status, got_r.status);
          if (got_r.blk !== want.blk)
            $display("%0t: block exp %0d got %0d", $realtime, want.blk, got_r.blk);
          if (got_r.entry !== want.entry)
            $display("%0t: entry exp %0d got %0d", $realtime, want.entry, got_r.entry);
          if (out_tdata[15:14] !== 2'b00)
            $display("%0t: pad exp 0 got %0d", $realtime, out_tdata[15:14]);
          if (got_r !== want || out_tdata[15:14] !== 2'b00) fail_count++;
        end
      end
    end
  end
endmodule

>>> bench/file_table_block_allocator_unit_tb.sv
// -----------------------------------------------------------------------------
// file_table_block_allocator_unit_tb
// Directed and random create/delete/look up and unknown-command traffic with
// random stalls on both streams; the checker predicts and compares every result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module file_table_block_allocator_unit_tb;
  import ftba_pkg::*;

  localparam logic [1:0] CMD_BOGUS = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  int          fail_count, pending;
  int          send_idle_pct = 17, recv_idle_pct = 54;
  bit          recv_hold = 0;

  logic [63:0] live_names[$];

  always #10 clk = ~clk;

  file_table_block_allocator_unit u_top (.*);

  file_table_block_allocator_unit_checker u_chk (.*);

  // receiver: random stalls, plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after the accepting edge until the next idle or drain
  task automatic send_cmd(logic [1:0] cmd, logic [63:0] nm, logic [3:0] sz, logic [2:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'd0, idx, sz, nm, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [63:0] rand_name();
    return {$urandom, $urandom};
  endfunction

  task automatic random_cmd();
    logic [63:0] nm;
    int          pick;
    pick = $urandom_range(99);
    if (live_names.size() > 0 && pick < 55)
      nm = live_names[$urandom_range(live_names.size() - 1)];
    else if (pick < 85)
      nm = {60'd0, 4'($urandom_range(15))};
    else
      nm = rand_name();
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_cmd(CMD_CREATE, nm, ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                                           : 4'($urandom_range(8)), 3'($urandom));
      live_names.push_back(nm);
      if (live_names.size() > 24) live_names.pop_front();
    end else if (pick < 62) send_cmd(CMD_DELETE, nm, 4'($urandom), 3'($urandom));
    else if (pick < 97) send_cmd(CMD_LOOKUP, nm, 4'($urandom), 3'($urandom));
    else send_cmd(CMD_BOGUS, nm, 4'($urandom), 3'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #10000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_cmd(CMD_LOOKUP, 64'd1, 4'd0, 3'd0);
    send_cmd(CMD_DELETE, 64'd1, 4'd0, 3'd0);
    send_cmd(CMD_CREATE, '1, 4'd15, 3'd7);
    send_cmd(CMD_CREATE, '1, 4'd9, 3'd0);
    send_cmd(CMD_CREATE, '1, 4'd8, 3'd0);
    send_cmd(CMD_CREATE, '1, 4'd1, 3'd0);
    send_cmd(CMD_LOOKUP, '1, 4'd0, 3'd7);
    send_cmd(CMD_LOOKUP, '1, 4'd0, 3'd0);
    send_cmd(CMD_CREATE, 64'd0, 4'd0, 3'd0);
    send_cmd(CMD_LOOKUP, 64'd0, 4'd0, 3'd0);
    send_cmd(CMD_BOGUS, '1, 4'd15, 3'd7);
    send_cmd(CMD_DELETE, '1, 4'd0, 3'd0);
    send_cmd(CMD_LOOKUP, '1, 4'd0, 3'd1);
    for (int i = 2; i < 18; i++) send_cmd(CMD_CREATE, 64'(i), 4'd8, 3'd0);
    send_cmd(CMD_DELETE, 64'd0, 4'd0, 3'd0);
    drain();
    // fill the disk so no-space shows up, then clear the table
    for (int i = 0; i < 18; i++) send_cmd(CMD_DELETE, 64'(i), 4'd0, 3'd0);
    for (int i = 20; i < 36; i++) send_cmd(CMD_CREATE, 64'(i), 4'd8, 3'd0);
    send_cmd(CMD_DELETE, 64'd20, 4'd0, 3'd0);
    send_cmd(CMD_CREATE, 64'd40, 4'd8, 3'd0);
    for (int i = 20; i < 36; i++) send_cmd(CMD_DELETE, 64'(i), 4'd0, 3'd0);
    drain();
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        recv_hold = 1;
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      begin
        for (int i = 0; i < 20; i++) random_cmd();
        in_tvalid <= 0;
        @(posedge clk);
      end
    join
    drain();
    for (int i = 0; i < 600; i++) random_cmd();
    drain();
    send_idle_pct = 54; recv_idle_pct = 17;
    for (int i = 0; i < 600; i++) random_cmd();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 600; i++) random_cmd();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
